// ===== design/pgrd_pkg.sv =====
// Shared types and constants for the glyph raster decoder.
// Used by pgrd_ctrl, pgrd_dp, the top level and the checker.
package pgrd_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_DYN_FACTOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLACK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd3;

	localparam logic [3:0] DYN_RAW     = 4'd14;
	localparam logic [3:0] NIB_REP_NUM = 4'd14;
	localparam logic [3:0] NIB_REP_ONE = 4'd15;
	localparam logic [3:0] DYN_TOP     = 4'd13;
	localparam logic [3:0] ZERO_SAT    = 4'd15;
	localparam logic [6:0] REP_MAX     = 7'd127;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_ZEROS,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		NK_NONE,
		NK_PAINT,
		NK_ERR
	} nib_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NIB,
		S_PAINT,
		S_RAW,
		S_FIN,
		S_FIN_CLR,
		S_ERR
	} state_t;

	typedef struct packed {
		logic accept;
		logic nib_exec;
		logic nib_next;
		logic paint;
		logic paint_end;
		logic raw_bit;
		logic emit_row;
		logic fin_clr;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic      raw_mode;
		logic      glyph_done;
		logic      col_ge_w;
		logic      raw_rem_zero;
		logic      nib_sel;
		logic      count_zero;
		logic      fill_ends_row;
		logic      rows_ge_h;
		logic      repeat_zero;
		logic      out_free;
		nib_kind_t nib_kind;
	} sts_t;

endpackage

// ===== design/pk_glyph_raster_decoder_unit.sv =====
// Flow: a byte is taken while the sequencer is idle, then its nibbles are
// parsed (run-length mode) or its pixel bits are written to the row buffer
// (raw mode); a run is painted row segment by row segment, and each completed
// row is sent once per copy, waiting while the output is held, then cleared.
// A new byte is taken only once the sequencer is idle again.
// Reset (arst_n low) clears sequencer, glyph state and output.
// Top level: joins pgrd_ctrl and pgrd_dp; depends on pgrd_pkg.
module pk_glyph_raster_decoder_unit #(
	parameter int MAX_WIDTH  = pgrd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pgrd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pgrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgrd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      packed_byte,
	input  logic                            glyph_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [MAX_WIDTH-1:0]            row_pixels,
	output logic [$clog2(MAX_HEIGHT)-1:0]   row_number,
	output logic                            last_row,
	output logic                            repeat_error
);

	pgrd_pkg::cmd_t cmd;
	pgrd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pgrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pgrd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.packed_byte  (packed_byte),
		.glyph_start  (glyph_start),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.row_pixels   (row_pixels),
		.row_number   (row_number),
		.last_row     (last_row),
		.repeat_error (repeat_error)
	);

endmodule

// ===== design/pgrd_ctrl.sv =====
// Sequencer for the glyph raster decoder: walks nibbles, raw bits, run
// painting and row emission. Depends on pgrd_pkg; drives pgrd_dp by commands.
module pgrd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pgrd_pkg::sts_t sts,
	output pgrd_pkg::cmd_t cmd
);

	pgrd_pkg::state_t state_q, state_d;
	logic ret_raw_q, ret_raw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pgrd_pkg::S_IDLE;
			ret_raw_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_raw_q <= ret_raw_d;
		end
	end

	// next state
	always_comb begin
		state_d   = state_q;
		ret_raw_d = ret_raw_q;
		case (state_q)
			pgrd_pkg::S_IDLE: begin
				if (in_valid)
					state_d = sts.raw_mode ? pgrd_pkg::S_RAW : pgrd_pkg::S_NIB;
			end
			pgrd_pkg::S_NIB: begin
				if (sts.glyph_done)
					state_d = pgrd_pkg::S_IDLE;
				else if (sts.nib_kind == pgrd_pkg::NK_ERR)
					state_d = pgrd_pkg::S_ERR;
				else if (sts.nib_kind == pgrd_pkg::NK_PAINT)
					state_d = pgrd_pkg::S_PAINT;
				else if (sts.nib_sel)
					state_d = pgrd_pkg::S_IDLE;
			end
			pgrd_pkg::S_PAINT: begin
				if (sts.glyph_done || sts.count_zero) begin
					state_d = sts.nib_sel ? pgrd_pkg::S_IDLE : pgrd_pkg::S_NIB;
				end else if (sts.col_ge_w || sts.fill_ends_row) begin
					state_d   = pgrd_pkg::S_FIN;
					ret_raw_d = 1'b0;
				end
			end
			pgrd_pkg::S_RAW: begin
				if (sts.glyph_done) begin
					state_d = pgrd_pkg::S_IDLE;
				end else if (sts.col_ge_w) begin
					state_d   = pgrd_pkg::S_FIN;
					ret_raw_d = 1'b1;
				end else if (sts.raw_rem_zero) begin
					state_d = pgrd_pkg::S_IDLE;
				end
			end
			pgrd_pkg::S_FIN: begin
				if (sts.rows_ge_h)
					state_d = pgrd_pkg::S_FIN_CLR;
				else if (sts.out_free && sts.repeat_zero)
					state_d = pgrd_pkg::S_FIN_CLR;
			end
			pgrd_pkg::S_FIN_CLR: begin
				state_d = ret_raw_q ? pgrd_pkg::S_RAW : pgrd_pkg::S_PAINT;
			end
			pgrd_pkg::S_ERR: begin
				if (sts.out_free)
					state_d = pgrd_pkg::S_IDLE;
			end
			default: state_d = pgrd_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pgrd_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			pgrd_pkg::S_NIB: begin
				if (!sts.glyph_done) begin
					cmd.nib_exec = 1'b1;
					cmd.nib_next = (sts.nib_kind == pgrd_pkg::NK_NONE) && !sts.nib_sel;
				end
			end
			pgrd_pkg::S_PAINT: begin
				if (sts.glyph_done || sts.count_zero) begin
					cmd.paint_end = 1'b1;
					cmd.nib_next  = !sts.nib_sel;
				end else if (!sts.col_ge_w) begin
					cmd.paint = 1'b1;
				end
			end
			pgrd_pkg::S_RAW: begin
				cmd.raw_bit = !sts.glyph_done && !sts.col_ge_w && !sts.raw_rem_zero;
			end
			pgrd_pkg::S_FIN: begin
				cmd.emit_row = !sts.rows_ge_h && sts.out_free;
			end
			pgrd_pkg::S_FIN_CLR: begin
				cmd.fin_clr = 1'b1;
			end
			pgrd_pkg::S_ERR: begin
				cmd.emit_err = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/pgrd_dp.sv =====
// Datapath of the glyph raster decoder: config registers, nibble parser,
// row buffer, run painter and output register. Depends on pgrd_pkg.
module pgrd_dp #(
	parameter int MAX_WIDTH  = pgrd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pgrd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [pgrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pgrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                        packed_byte,
	input  logic                              glyph_start,
	input  pgrd_pkg::cmd_t                    cmd,
	output pgrd_pkg::sts_t                    sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [MAX_WIDTH-1:0]              row_pixels,
	output logic [$clog2(MAX_HEIGHT)-1:0]     row_number,
	output logic                              last_row,
	output logic                              repeat_error
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int IW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int NW = $clog2(MAX_HEIGHT);

	logic [3:0]           dyn_q;
	logic                 first_black_q;
	logic [6:0]           width_q, height_q;
	logic [7:0]           byte_q;
	logic                 nib_sel_q;
	logic [3:0]           raw_rem_q;
	logic [MAX_WIDTH-1:0] row_buf_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        rows_q;
	logic                 color_q;
	logic [6:0]           repeat_q;
	pgrd_pkg::phase_t     phase_q, phase_n;
	logic [3:0]           zeros_q, zeros_n;
	logic [31:0]          accum_q, accum_n;
	logic                 pend_q, pend_n;
	logic                 done_q;
	logic [31:0]          count_q;

	logic [CW-1:0] w_eff, room, take, col_take;
	logic [RW-1:0] h_eff;
	logic [3:0]    nib;
	logic          rep_wr, deliver, err, paint_go;
	logic [6:0]    rep_val;
	logic [31:0]   dcount;
	logic [3:0]    sec_first, sec_diff;
	logic [8:0]    sec_count;
	logic [31:0]   dig_acc, dig_count;
	logic [7:0]    dig_k;
	logic [32:0]   dig_sum, dig_sub;
	logic [MAX_WIDTH-1:0] mask;

	always_comb begin
		if (width_q == 7'd0)
			w_eff = CW'(1);
		else if (width_q > 7'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(width_q);
		if (height_q == 7'd0)
			h_eff = RW'(1);
		else if (height_q > 7'(MAX_HEIGHT))
			h_eff = RW'(MAX_HEIGHT);
		else
			h_eff = RW'(height_q);
	end

	assign nib = nib_sel_q ? byte_q[3:0] : byte_q[7:4];

	// two-nibble run: stale prefix not above dyn_factor adds nothing
	assign sec_first = accum_q[3:0];
	assign sec_diff  = sec_first - dyn_q - 4'd1;
	assign sec_count = ((sec_first > dyn_q) ? {1'b0, sec_diff, 4'b0} : 9'd0)
		+ 9'(nib) + 9'(dyn_q) + 9'd1;

	// long packed number, saturating
	assign dig_acc   = (accum_q > 32'h0FFF_FFFF) ? '1 : {accum_q[27:0], nib};
	assign dig_k     = {pgrd_pkg::DYN_TOP - dyn_q, 4'b0} + {4'b0, dyn_q};
	assign dig_sum   = {1'b0, dig_acc} + 33'(dig_k);
	assign dig_sub   = dig_sum - 33'd15;
	assign dig_count = (dig_sum < 33'd15) ? 32'd0 : (dig_sub[32] ? '1 : dig_sub[31:0]);

	always_comb begin
		phase_n = phase_q;
		zeros_n = zeros_q;
		accum_n = accum_q;
		pend_n  = pend_q;
		rep_wr  = 1'b0;
		rep_val = '0;
		deliver = 1'b0;
		dcount  = '0;
		err     = 1'b0;
		paint_go = 1'b0;
		case (phase_q)
			pgrd_pkg::PH_FIRST: begin
				if (nib >= pgrd_pkg::NIB_REP_NUM) begin
					if (pend_q) begin
						err = 1'b1;
					end else if (nib == pgrd_pkg::NIB_REP_ONE) begin
						rep_wr  = 1'b1;
						rep_val = 7'd1;
					end else begin
						pend_n = 1'b1;
					end
				end else if (nib == 4'd0) begin
					zeros_n = 4'd1;
					phase_n = pgrd_pkg::PH_ZEROS;
				end else if (nib <= dyn_q) begin
					deliver = 1'b1;
					dcount  = 32'(nib);
				end else begin
					accum_n = 32'(nib);
					phase_n = pgrd_pkg::PH_SECOND;
				end
			end
			pgrd_pkg::PH_SECOND: begin
				phase_n = pgrd_pkg::PH_FIRST;
				deliver = 1'b1;
				dcount  = 32'(sec_count);
			end
			pgrd_pkg::PH_ZEROS: begin
				if (nib == 4'd0) begin
					if (zeros_q < pgrd_pkg::ZERO_SAT)
						zeros_n = zeros_q + 4'd1;
				end else begin
					accum_n = 32'(nib);
					phase_n = pgrd_pkg::PH_DIGITS;
				end
			end
			pgrd_pkg::PH_DIGITS: begin
				accum_n = dig_acc;
				zeros_n = (zeros_q != 4'd0) ? zeros_q - 4'd1 : 4'd0;
				if (zeros_n == 4'd0) begin
					phase_n = pgrd_pkg::PH_FIRST;
					deliver = 1'b1;
					dcount  = dig_count;
				end
			end
			default: phase_n = pgrd_pkg::PH_FIRST;
		endcase
		if (deliver) begin
			if (pend_q) begin
				pend_n  = 1'b0;
				rep_wr  = 1'b1;
				rep_val = (dcount > 32'(pgrd_pkg::REP_MAX)) ? pgrd_pkg::REP_MAX : dcount[6:0];
			end else begin
				paint_go = 1'b1;
			end
		end
	end

	// run painter: one row segment per cycle, pausing while a finished row is sent and cleared
	assign room     = w_eff - col_q;
	assign take     = (count_q < 32'(room)) ? count_q[CW-1:0] : room;
	assign col_take = col_q + take;

	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++)
			mask[j] = (CW'(j) >= col_q) && (CW'(j) < col_take);
	end

	always_comb begin
		sts.raw_mode      = dyn_q >= pgrd_pkg::DYN_RAW;
		sts.glyph_done    = done_q;
		sts.col_ge_w      = col_q >= w_eff;
		sts.raw_rem_zero  = raw_rem_q == 4'd0;
		sts.nib_sel       = nib_sel_q;
		sts.count_zero    = count_q == 32'd0;
		sts.fill_ends_row = count_q >= 32'(room);
		sts.rows_ge_h     = rows_q >= h_eff;
		sts.repeat_zero   = repeat_q == 7'd0;
		sts.out_free      = !out_valid || out_ready;
		sts.nib_kind      = err ? pgrd_pkg::NK_ERR :
			(paint_go ? pgrd_pkg::NK_PAINT : pgrd_pkg::NK_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dyn_q         <= '0;
			first_black_q <= 1'b0;
			width_q       <= 7'd1;
			height_q      <= 7'd1;
			byte_q        <= '0;
			nib_sel_q     <= 1'b0;
			raw_rem_q     <= '0;
			row_buf_q     <= '0;
			col_q         <= '0;
			rows_q        <= '0;
			color_q       <= 1'b0;
			repeat_q      <= '0;
			phase_q       <= pgrd_pkg::PH_FIRST;
			zeros_q       <= '0;
			accum_q       <= '0;
			pend_q        <= 1'b0;
			done_q        <= 1'b0;
			count_q       <= '0;
			out_valid     <= 1'b0;
			row_pixels    <= '0;
			row_number    <= '0;
			last_row      <= 1'b0;
			repeat_error  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pgrd_pkg::REG_DYN_FACTOR:   dyn_q         <= cfg_data[3:0];
					pgrd_pkg::REG_FIRST_BLACK:  first_black_q <= cfg_data[0];
					pgrd_pkg::REG_GLYPH_WIDTH:  width_q       <= cfg_data[6:0];
					pgrd_pkg::REG_GLYPH_HEIGHT: height_q      <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (cmd.accept) begin
				byte_q    <= packed_byte;
				nib_sel_q <= 1'b0;
				raw_rem_q <= 4'd8;
				if (glyph_start) begin
					row_buf_q <= '0;
					col_q     <= '0;
					rows_q    <= '0;
					color_q   <= first_black_q;
					repeat_q  <= '0;
					phase_q   <= pgrd_pkg::PH_FIRST;
					zeros_q   <= '0;
					accum_q   <= '0;
					pend_q    <= 1'b0;
					done_q    <= 1'b0;
				end else if (rows_q >= h_eff) begin
					done_q <= 1'b1;
				end
			end

			if (cmd.nib_next)
				nib_sel_q <= 1'b1;

			if (cmd.nib_exec && !err) begin
				phase_q <= phase_n;
				zeros_q <= zeros_n;
				accum_q <= accum_n;
				pend_q  <= pend_n;
				if (rep_wr)
					repeat_q <= rep_val;
				if (paint_go)
					count_q <= dcount;
			end

			if (cmd.paint) begin
				if (color_q)
					row_buf_q <= row_buf_q | mask;
				col_q   <= col_take;
				count_q <= count_q - 32'(take);
			end

			if (cmd.paint_end)
				color_q <= ~color_q;

			if (cmd.raw_bit) begin
				if (byte_q[7])
					row_buf_q[col_q[IW-1:0]] <= 1'b1;
				col_q     <= col_q + CW'(1);
				byte_q    <= {byte_q[6:0], 1'b0};
				raw_rem_q <= raw_rem_q - 4'd1;
			end

			if (cmd.emit_row) begin
				row_pixels   <= row_buf_q;
				row_number   <= rows_q[NW-1:0];
				last_row     <= RW'(rows_q + RW'(1)) == h_eff;
				repeat_error <= 1'b0;
				rows_q       <= rows_q + RW'(1);
				if (repeat_q != 7'd0)
					repeat_q <= repeat_q - 7'd1;
			end

			if (cmd.fin_clr) begin
				row_buf_q <= '0;
				col_q     <= '0;
				repeat_q  <= '0;
				done_q    <= rows_q >= h_eff;
			end

			if (cmd.emit_err) begin
				row_pixels   <= '0;
				row_number   <= '0;
				last_row     <= 1'b1;
				repeat_error <= 1'b1;
				done_q       <= 1'b1;
			end

			if (cmd.emit_row || cmd.emit_err)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule

// ===== design/pgrd_chk.sv =====
// Port-level checker for pk_glyph_raster_decoder_unit, bound to the top level.
// Depends on pgrd_pkg for default sizes.
module pgrd_chk #(
	parameter int MAX_WIDTH  = pgrd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pgrd_pkg::DEF_MAX_HEIGHT
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [MAX_WIDTH-1:0]          row_pixels,
	input logic [$clog2(MAX_HEIGHT)-1:0] row_number,
	input logic                          last_row,
	input logic                          repeat_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(row_pixels) && $stable(row_number))
		else $error("output payload changed while stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_error |-> last_row && row_pixels == '0 && row_number == '0)
		else $error("error result carries row data");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("byte taken while previous byte still in work");

endmodule

bind pk_glyph_raster_decoder_unit pgrd_chk #(
	.MAX_WIDTH  (MAX_WIDTH),
	.MAX_HEIGHT (MAX_HEIGHT)
) u_pgrd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.row_pixels   (row_pixels),
	.row_number   (row_number),
	.last_row     (last_row),
	.repeat_error (repeat_error)
);

// ===== test/pk_glyph_raster_decoder_unit_check.sv =====
// Row checker for the glyph raster decoder: watches the byte, config and row
// channels, predicts rows from the decoded glyph state and compares.
// Depends on pgrd_pkg.
module pk_glyph_raster_decoder_unit_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  packed_byte,
	input  logic        glyph_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] row_pixels,
	input  logic [5:0]  row_number,
	input  logic        last_row,
	input  logic        repeat_error,
	output int          fail_count,
	output int          rows_pending
);

	typedef struct packed {
		logic [63:0] pixels;
		logic [5:0]  num;
		logic        last;
		logic        err;
	} row_t;

	row_t expected_rows[$];

	// configuration copy
	logic [3:0] dyn;
	logic       fblack;
	logic [6:0] gw, gh;

	// glyph state
	logic [63:0] rbuf;
	int unsigned col, rows, color, rep, zeros, accum;
	pgrd_pkg::phase_t phase;
	logic        rep_pend, done;

	assign rows_pending = expected_rows.size();

	function automatic int unsigned width_eff();
		return (gw < 1) ? 1 : (gw > 64) ? 64 : gw;
	endfunction

	function automatic int unsigned height_eff();
		return (gh < 1) ? 1 : (gh > 64) ? 64 : gh;
	endfunction

	task automatic clear_glyph();
		rbuf = '0; col = 0; rows = 0; color = fblack; rep = 0;
		phase = pgrd_pkg::PH_FIRST; zeros = 0; accum = 0; rep_pend = 0; done = 0;
	endtask

	task automatic push_row(logic [63:0] p, int unsigned n, logic l, logic e);
		row_t r;
		r.pixels = p; r.num = n[5:0]; r.last = l; r.err = e;
		expected_rows.push_back(r);
	endtask

	task automatic close_row();
		int unsigned h, times;
		h = height_eff();
		times = rep + 1;
		while (times > 0 && rows < h) begin
			push_row(rbuf, rows, rows + 1 == h, 1'b0);
			rows++;
			times--;
		end
		rbuf = '0; col = 0; rep = 0;
		if (rows >= h) done = 1;
	endtask

	task automatic paint(int unsigned count);
		int unsigned w, take;
		logic [63:0] m;
		while (count > 0 && !done) begin
			w = width_eff();
			if (col >= w) begin
				close_row();
				continue;
			end
			take = w - col;
			if (count < take) take = count;
			if (color != 0) begin
				m = (take >= 64) ? '1 : ((64'd1 << take) - 64'd1);
				rbuf |= m << col;
			end
			col += take;
			count -= take;
			if (col >= w) close_row();
		end
		color ^= 1;
	endtask

	task automatic take_count(int unsigned c);
		if (rep_pend) begin
			rep_pend = 0;
			rep = (c > pgrd_pkg::REP_MAX) ? pgrd_pkg::REP_MAX : c;
		end else
			paint(c);
	endtask

	task automatic decode_nibble(int unsigned n);
		int unsigned hi;
		longint unsigned c;
		if (done) return;
		case (phase)
			pgrd_pkg::PH_FIRST: begin
				if (n >= pgrd_pkg::NIB_REP_NUM) begin
					if (rep_pend) begin
						push_row('0, 0, 1'b1, 1'b1);
						done = 1;
					end else if (n == pgrd_pkg::NIB_REP_ONE)
						rep = 1;
					else
						rep_pend = 1;
				end else if (n == 0) begin
					zeros = 1; phase = pgrd_pkg::PH_ZEROS;
				end else if (n <= dyn)
					take_count(n);
				else begin
					accum = n; phase = pgrd_pkg::PH_SECOND;
				end
			end
			pgrd_pkg::PH_SECOND: begin
				hi = (accum > dyn) ? (accum - dyn - 1) * 16 : 0;
				phase = pgrd_pkg::PH_FIRST;
				take_count(hi + n + dyn + 1);
			end
			pgrd_pkg::PH_ZEROS: begin
				if (n == 0) begin
					if (zeros < pgrd_pkg::ZERO_SAT) zeros++;
				end else begin
					accum = n; phase = pgrd_pkg::PH_DIGITS;
				end
			end
			default: begin
				if (accum > 32'h0FFF_FFFF) accum = 32'hFFFF_FFFF;
				else accum = accum * 16 + n;
				if (zeros > 0) zeros--;
				if (zeros == 0) begin
					phase = pgrd_pkg::PH_FIRST;
					c = longint'(accum) + (pgrd_pkg::DYN_TOP - dyn) * 16 + dyn;
					c = (c >= 15) ? c - 15 : 0;
					if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
					take_count(c[31:0]);
				end
			end
		endcase
	endtask

	task automatic decode_byte(logic [7:0] b, logic start);
		int unsigned w;
		if (start) clear_glyph();
		if (rows >= height_eff()) done = 1;
		if (done) return;
		if (dyn >= pgrd_pkg::DYN_RAW) begin
			for (int i = 7; i >= 0; i--) begin
				w = width_eff();
				if (done) return;
				if (col >= w) begin
					close_row();
					if (done) return;
				end
				if (b[i]) rbuf[col] = 1'b1;
				col++;
				if (col >= w) close_row();
			end
		end else begin
			decode_nibble(b[7:4]);
			decode_nibble(b[3:0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		row_t e;
		if (!arst_n) begin
			dyn = 0; fblack = 0; gw = 1; gh = 1;
			clear_glyph();
			expected_rows.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					pgrd_pkg::REG_DYN_FACTOR:   dyn = cfg_data[3:0];
					pgrd_pkg::REG_FIRST_BLACK:  fblack = cfg_data[0];
					pgrd_pkg::REG_GLYPH_WIDTH:  gw = cfg_data;
					pgrd_pkg::REG_GLYPH_HEIGHT: gh = cfg_data;
					default: ;
				endcase
			if (out_valid && out_ready) begin
				if (expected_rows.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected row: num %0d pix %h", row_number, row_pixels);
				end else begin
					e = expected_rows.pop_front();
					if (e.pixels !== row_pixels || e.num !== row_number ||
					    e.last !== last_row || e.err !== repeat_error) begin
						fail_count++;
						if (fail_count <= 10)
							$display("row mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
								e.pixels, e.num, e.last, e.err,
								row_pixels, row_number, last_row, repeat_error);
					end
				end
			end
			if (in_valid && in_ready) decode_byte(packed_byte, glyph_start);
		end
	end
endmodule

// ===== test/pk_glyph_raster_decoder_unit_test.sv =====
// Testbench top for the glyph raster decoder: drives config and packed bytes
// with random gaps and stalls, and gives the verdict from the row checker.
// Depends on pgrd_pkg, pk_glyph_raster_decoder_unit and its checker.
module pk_glyph_raster_decoder_unit_test;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0, cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 0, in_ready;
	logic [7:0]  packed_byte = '0;
	logic        glyph_start = 0;
	logic        out_valid, out_ready = 0;
	logic [63:0] row_pixels;
	logic [5:0]  row_number;
	logic        last_row, repeat_error;
	int          fail_count, rows_pending;
	bit          hold_off = 0;

	always #5 clk = ~clk;

	pk_glyph_raster_decoder_unit dut (.*);

	pk_glyph_raster_decoder_unit_check checker_i (.*);

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_byte(logic [7:0] b, logic s);
		repeat ($urandom_range(0, 10) * ($urandom_range(0, 3) != 0)) @(negedge clk);
		@(negedge clk);
		in_valid <= 1; packed_byte <= b; glyph_start <= s;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 0;
	endtask

	// wait until every predicted row is out, then let a trailing run settle
	task automatic drain();
		while (rows_pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_glyph(int unsigned d, int unsigned fb, int unsigned w,
	                         int unsigned h);
		write_reg(pgrd_pkg::REG_DYN_FACTOR, 7'(d));
		write_reg(pgrd_pkg::REG_FIRST_BLACK, 7'(fb));
		write_reg(pgrd_pkg::REG_GLYPH_WIDTH, 7'(w));
		write_reg(pgrd_pkg::REG_GLYPH_HEIGHT, 7'(h));
	endtask

	// receiver: random gap before each row, plus one long hold-off when asked
	initial begin
		int unsigned gap;
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			gap = $urandom_range(0, 10);
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("pk_glyph_raster_decoder_unit_test failed");
		$finish;
	end

	initial begin
		int unsigned d, w, h, n, k;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: raw mode, extremes, repeats, errors, large numbers
		set_glyph(pgrd_pkg::DYN_RAW, 0, 64, 2);
		for (int i = 0; i < 8; i++) send_byte(i == 0 ? 8'hFF : 8'hA5, i == 0);
		send_byte(8'h00, 0);
		drain();
		set_glyph(15, 1, 1, 1);
		send_byte(8'h80, 1);
		drain();
		set_glyph(13, 1, 5, 4);
		send_byte(8'hF3, 1); send_byte(8'h2D, 0); send_byte(8'hE1, 0);
		send_byte(8'h1F, 0);
		drain();
		set_glyph(0, 0, 8, 8);
		send_byte(8'hEE, 1); send_byte(8'h00, 1); send_byte(8'h01, 0);
		send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'hFF, 0);
		send_byte(8'hFF, 0); send_byte(8'hE0, 0); send_byte(8'h1F, 0);
		drain();
		set_glyph(7, 0, 100, 0);
		send_byte(8'h9C, 1); send_byte(8'hE9, 0); send_byte(8'hF3, 0);
		send_byte(8'h11, 0);
		drain();

		// fill-up: long receiver hold-off with a tall raw-mode glyph
		set_glyph(pgrd_pkg::DYN_RAW, 1, 8, 64);
		hold_off = 1;
		for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 0);
		drain();

		// random glyphs, mostly small
		n = 0;
		while (n < 380) begin
			d = $urandom_range(0, 15);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
			set_glyph(d, $urandom_range(0, 1), w, h);
			k = $urandom_range(3, 20);
			for (int i = 0; i < k; i++) begin
				logic [7:0] b;
				b = 8'($urandom);
				// favor short runs so glyphs actually complete
				if ($urandom_range(0, 2) != 0 && d < pgrd_pkg::DYN_RAW)
					b = {4'($urandom_range(1, 13)), 4'($urandom_range(1, 13))};
				send_byte(b, i == 0 || $urandom_range(0, 30) == 0);
				n++;
			end
			drain();
		end

		if (fail_count == 0)
			$display("pk_glyph_raster_decoder_unit_test passed");
		else
			$display("pk_glyph_raster_decoder_unit_test failed");
		$finish;
	end
endmodule
